@@ rtl/cse_pkg.sv @@
// Package: constants, payload types and helpers for the cubic segment evaluator.
`default_nettype none

package cse_pkg;

	localparam int COORD_BITS    = 16;
	localparam int FRACTION_BITS = 16;
	localparam int NUM_LANES     = 3;
	localparam int NUM_TAPS      = 4;
	localparam int POINT_BITS    = 48;

	localparam int T_W    = FRACTION_BITS + 1;
	localparam int W_W    = FRACTION_BITS + 3;
	localparam int HW_W   = FRACTION_BITS + 4;
	localparam int PROD_W = COORD_BITS + W_W;
	localparam int ACC_W  = PROD_W + 2;
	localparam int Q_W    = ACC_W + 1 - FRACTION_BITS;

	localparam logic [T_W-1:0] ONE  = {1'b1, {FRACTION_BITS{1'b0}}};
	localparam logic [T_W-1:0] HALF = {2'b01, {(FRACTION_BITS - 1){1'b0}}};

	typedef enum logic [1:0] {
		MODE_LINEAR  = 2'd0,
		MODE_BEZIER  = 2'd1,
		MODE_HERMITE = 2'd2
	} curve_mode_t;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [W_W-1:0]        weight_t;
	typedef weight_t [NUM_TAPS-1:0]       weight_set_t;
	typedef coord_t  [NUM_TAPS-1:0]       coord_set_t;
	typedef coord_t  [NUM_LANES-1:0]      lane_res_t;

	typedef struct packed {
		logic [POINT_BITS-1:0] point_a;
		logic [POINT_BITS-1:0] point_b;
		logic [POINT_BITS-1:0] point_c;
		logic [POINT_BITS-1:0] point_d;
		logic [T_W-1:0]        blend_fraction;
	} in_word_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] value_x;
		logic signed [COORD_BITS-1:0] value_y;
		logic signed [COORD_BITS-1:0] value_z;
	} out_word_t;

	// per-stage advance strobes
	typedef struct packed {
		logic s8;
		logic s7;
		logic s6;
		logic s5;
		logic s4;
		logic s3;
		logic s2;
		logic s1;
	} pipe_adv_t;

	// round-to-nearest of a non-negative product of two fractions
	function automatic logic [T_W-1:0] rnd_frac(input logic [2*T_W-1:0] x);
		logic [2*T_W:0] y;
		y = {1'b0, x} + (2*T_W+1)'(HALF);
		return y[FRACTION_BITS+T_W-1:FRACTION_BITS];
	endfunction

endpackage

`default_nettype wire

@@ rtl/cse_weight_gen.sv @@
// Blend weight pipeline: clamp, powers of t and 1-t, per-mode basis weights.
`default_nettype none

module cse_weight_gen
	import cse_pkg::*;
(
	input  wire logic        clk,
	input  wire pipe_adv_t   adv,
	input  wire curve_mode_t mode,
	input  wire [T_W-1:0]    blend_fraction,
	output weight_set_t      weights_s4
);

	logic [T_W-1:0] t_clamp;
	logic [T_W-1:0] t_s1, s_s1;
	logic [T_W-1:0] t_s2, s_s2, t2_s2, s2_s2;
	logic [T_W-1:0] t_s3, t2_s3, t3_s3, s_s3, s3_s3, ts2_s3, t2s_s3;
	curve_mode_t    mode_s1, mode_s2, mode_s3;

	logic signed [HW_W-1:0] t_e, t2_e, t3_e, s_e, s3_e, ts2_e, t2s_e, one_e;
	weight_t                w_nxt [NUM_TAPS];

	assign t_clamp = (blend_fraction > ONE) ? ONE : blend_fraction;

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			t_s1    <= t_clamp;
			s_s1    <= ONE - t_clamp;
			mode_s1 <= mode;
		end
		if (adv.s2) begin
			t_s2    <= t_s1;
			s_s2    <= s_s1;
			t2_s2   <= rnd_frac(t_s1 * t_s1);
			s2_s2   <= rnd_frac(s_s1 * s_s1);
			mode_s2 <= mode_s1;
		end
		if (adv.s3) begin
			t_s3    <= t_s2;
			s_s3    <= s_s2;
			t2_s3   <= t2_s2;
			t3_s3   <= rnd_frac(t2_s2 * t_s2);
			s3_s3   <= rnd_frac(s2_s2 * s_s2);
			ts2_s3  <= rnd_frac(t_s2 * s2_s2);
			t2s_s3  <= rnd_frac(t2_s2 * s_s2);
			mode_s3 <= mode_s2;
		end
	end

	assign t_e   = $signed(HW_W'(t_s3));
	assign t2_e  = $signed(HW_W'(t2_s3));
	assign t3_e  = $signed(HW_W'(t3_s3));
	assign s_e   = $signed(HW_W'(s_s3));
	assign s3_e  = $signed(HW_W'(s3_s3));
	assign ts2_e = $signed(HW_W'(ts2_s3));
	assign t2s_e = $signed(HW_W'(t2s_s3));
	assign one_e = $signed(HW_W'(ONE));

	always_comb begin
		case (mode_s3)
			MODE_LINEAR: begin
				w_nxt[0] = W_W'(s_e);
				w_nxt[1] = '0;
				w_nxt[2] = '0;
				w_nxt[3] = W_W'(t_e);
			end
			MODE_BEZIER: begin
				w_nxt[0] = W_W'(s3_e);
				w_nxt[1] = W_W'(ts2_e + (ts2_e <<< 1));
				w_nxt[2] = W_W'(t2s_e + (t2s_e <<< 1));
				w_nxt[3] = W_W'(t3_e);
			end
			MODE_HERMITE: begin
				w_nxt[0] = W_W'((t3_e <<< 1) - (t2_e + (t2_e <<< 1)) + one_e);
				w_nxt[1] = W_W'(t3_e - (t2_e <<< 1) + t_e);
				w_nxt[2] = W_W'((t2_e + (t2_e <<< 1)) - (t3_e <<< 1));
				w_nxt[3] = W_W'(t3_e - t2_e);
			end
			default: begin
				w_nxt[0] = '0;
				w_nxt[1] = '0;
				w_nxt[2] = '0;
				w_nxt[3] = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv.s4) begin
			for (int k = 0; k < NUM_TAPS; k++) begin
				weights_s4[k] <= w_nxt[k];
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/cse_lane.sv @@
// One coordinate lane: weighted sum of four control coordinates, round, saturate.
`default_nettype none

module cse_lane
	import cse_pkg::*;
(
	input  wire logic        clk,
	input  wire pipe_adv_t   adv,
	input  wire coord_set_t  coords,
	input  wire weight_set_t weights_s4,
	output coord_t           res_s7
);

	coord_set_t                c_s1, c_s2, c_s3, c_s4;
	logic signed [PROD_W-1:0]  prod_s5 [NUM_TAPS];
	logic signed [ACC_W-1:0]   sum_s6;
	logic        [ACC_W:0]     biased;
	logic        [Q_W-1:0]     q;
	logic [Q_W-COORD_BITS:0]   upper;
	coord_t                    sat;

	always_ff @(posedge clk) begin
		if (adv.s1) c_s1 <= coords;
		if (adv.s2) c_s2 <= c_s1;
		if (adv.s3) c_s3 <= c_s2;
		if (adv.s4) c_s4 <= c_s3;
		if (adv.s5) begin
			for (int k = 0; k < NUM_TAPS; k++) begin
				prod_s5[k] <= c_s4[k] * weights_s4[k];
			end
		end
		if (adv.s6) begin
			sum_s6 <= ACC_W'(prod_s5[0]) + ACC_W'(prod_s5[1])
				+ ACC_W'(prod_s5[2]) + ACC_W'(prod_s5[3]);
		end
		if (adv.s7) res_s7 <= sat;
	end

	// floor((acc + half) / one), ties toward +inf
	assign biased = {sum_s6[ACC_W-1], sum_s6} + (ACC_W+1)'(HALF);
	assign q      = biased[ACC_W:FRACTION_BITS];
	assign upper  = q[Q_W-1:COORD_BITS-1];

	always_comb begin
		if ((&upper) || !(|upper)) begin
			sat = q[COORD_BITS-1:0];
		end else if (q[Q_W-1]) begin
			sat = {1'b1, {(COORD_BITS - 1){1'b0}}};
		end else begin
			sat = {1'b0, {(COORD_BITS - 1){1'b1}}};
		end
	end

endmodule

`default_nettype wire

@@ rtl/cse_merge.sv @@
// Output stage: gathers the three lane results into the output word register.
`default_nettype none

module cse_merge
	import cse_pkg::*;
(
	input  wire logic      clk,
	input  wire pipe_adv_t adv,
	input  wire lane_res_t lane_res_s7,
	output out_word_t      out_word_q
);

	always_ff @(posedge clk) begin
		if (adv.s8) begin
			out_word_q.value_x <= lane_res_s7[0];
			out_word_q.value_y <= lane_res_s7[1];
			out_word_q.value_z <= lane_res_s7[2];
		end
	end

endmodule

`default_nettype wire

@@ rtl/cubic_segment_evaluator_unit.sv @@
// Top level: cubic segment evaluator with three coordinate lanes.
//
// Evaluates one xyz point of a linear, cubic Bezier or cubic Hermite segment per word.
// The datapath is an eight-stage pipeline (clamp, two multiply stages for the powers
// of t and 1-t, weight select, lane multiply, lane sum, round/saturate, output
// register): one word is taken every cycle unless in_stall is high, and a result is
// presented from the output register after its word has passed every stage. Stages
// holding no word fill up while the output is stalled, so up to eight words are held
// before in_stall rises. curve_mode (reset: Bezier) is sampled as a word enters and
// should be written only with the pipeline empty; mode 3 gives an all-zero result.
`default_nettype none

module cubic_segment_evaluator_unit
	import cse_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      cfg_write,
	input  wire [1:0]      cfg_data,
	input  wire logic      in_valid,
	output logic           in_stall,
	input  wire in_word_t  in_word,
	output logic           out_valid,
	input  wire logic      out_stall,
	output out_word_t      out_word
);

	curve_mode_t  mode_q;
	logic [8:1]   stage_valid_q;
	logic [8:1]   adv_vec;
	pipe_adv_t    adv;
	weight_set_t  weights_s4;
	lane_res_t    lane_res_s7;
	coord_set_t   lane_coords [NUM_LANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_BEZIER;
		end else if (cfg_write) begin
			mode_q <= curve_mode_t'(cfg_data);
		end
	end

	// a stage moves when it is empty or the one after it moves
	always_comb begin
		adv_vec[8] = !stage_valid_q[8] || !out_stall;
		for (int k = 7; k >= 1; k--) begin
			adv_vec[k] = !stage_valid_q[k] || adv_vec[k+1];
		end
	end

	assign adv = pipe_adv_t'(adv_vec);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_valid_q <= '0;
		end else begin
			if (adv_vec[1]) stage_valid_q[1] <= in_valid;
			for (int k = 2; k <= 8; k++) begin
				if (adv_vec[k]) stage_valid_q[k] <= stage_valid_q[k-1];
			end
		end
	end

	assign in_stall  = !adv_vec[1];
	assign out_valid = stage_valid_q[8];

	cse_weight_gen u_weight_gen (
		.clk            (clk),
		.adv            (adv),
		.mode           (mode_q),
		.blend_fraction (in_word.blend_fraction),
		.weights_s4     (weights_s4)
	);

	for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
		assign lane_coords[i][0] = in_word.point_a[COORD_BITS*i +: COORD_BITS];
		assign lane_coords[i][1] = in_word.point_b[COORD_BITS*i +: COORD_BITS];
		assign lane_coords[i][2] = in_word.point_c[COORD_BITS*i +: COORD_BITS];
		assign lane_coords[i][3] = in_word.point_d[COORD_BITS*i +: COORD_BITS];

		cse_lane u_lane (
			.clk        (clk),
			.adv        (adv),
			.coords     (lane_coords[i]),
			.weights_s4 (weights_s4),
			.res_s7     (lane_res_s7[i])
		);
	end

	cse_merge u_merge (
		.clk         (clk),
		.adv         (adv),
		.lane_res_s7 (lane_res_s7),
		.out_word_q  (out_word)
	);

endmodule

`default_nettype wire

@@ rtl/cse_port_sva.sv @@
// Port-level assertions for the cubic segment evaluator, bound to the top level.
`default_nettype none

module cse_port_sva
	import cse_pkg::*;
(
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      cfg_write,
	input wire [1:0]      cfg_data,
	input wire logic      in_valid,
	input wire logic      in_stall,
	input wire in_word_t  in_word,
	input wire logic      out_valid,
	input wire logic      out_stall,
	input wire out_word_t out_word
);

	logic [3:0] inflight_q;
	logic [1:0] mode_seen_q;
	logic       in_acc, out_acc;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q  <= '0;
			mode_seen_q <= 2'(MODE_BEZIER);
		end else begin
			inflight_q <= inflight_q + 4'(in_acc) - 4'(out_acc);
			if (cfg_write) mode_seen_q <= cfg_data;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("out_valid dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_word))
		else $error("out_word changed while stalled");

	a_no_stall_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid || !out_stall |-> !in_stall)
		else $error("input stalled with a free output stage");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> inflight_q != 4'd0)
		else $error("result word without an accepted input word");

	a_unused_mode_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mode_seen_q == 2'd3 |-> out_word == '0)
		else $error("unused mode gave a nonzero result");

endmodule

bind cubic_segment_evaluator_unit cse_port_sva u_cse_port_sva (.*);

`default_nettype wire

@@ dv/tb_cubic_segment_evaluator_unit.sv @@
// Testbench: directed and random curve segments through the evaluator, each point checked.
module tb_cubic_segment_evaluator_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import cse_pkg::*;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam longint ONE_L = longint'(1) << FRACTION_BITS;
	localparam longint HALF_L = longint'(1) << (FRACTION_BITS - 1);
	localparam longint COORD_HI = (longint'(1) << (COORD_BITS - 1)) - 1;
	localparam longint COORD_LO = -(longint'(1) << (COORD_BITS - 1));
	localparam coord_t C_MAX = {1'b0, {(COORD_BITS - 1){1'b1}}};
	localparam coord_t C_MIN = {1'b1, {(COORD_BITS - 1){1'b0}}};
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 150;
	localparam int DRAIN_CYCLES = 16;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [1:0] cfg_data = 2'd0;
	logic in_valid = 1'b0;
	in_word_t in_word = '0;
	logic out_stall = 1'b0;
	logic in_stall;
	logic out_valid;
	out_word_t out_word;

	out_word_t expected_points[$];
	out_word_t next_point;
	logic [1:0] cur_mode = MODE_BEZIER;
	bit tx_gaps = 1'b1;
	bit rx_gaps = 1'b1;
	int hold_request = 0;
	int errors = 0;
	int points_checked = 0;
	int words_sent = 0;
	int words_per_mode[4] = '{0, 0, 0, 0};
	int cycle_count = 0;
	int in_stall_cycles = 0;

	cubic_segment_evaluator_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_write(cfg_write),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_word  (in_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word (out_word)
	);

	always #2 clk = ~clk;

	// round to nearest, ties up (floor of x/ONE + 1/2)
	function automatic longint scale_down(longint x);
		return (x + HALF_L) >>> FRACTION_BITS;
	endfunction

	function automatic out_word_t predict_point(in_word_t w, logic [1:0] mode);
		longint t, s, t2, t3, s2, s3, acc, q;
		longint wt[NUM_TAPS];
		logic [POINT_BITS-1:0] pts[NUM_TAPS];
		coord_t lane[NUM_LANES];
		out_word_t r;
		t = longint'(w.blend_fraction);
		if (t > ONE_L)
			t = ONE_L;
		s = ONE_L - t;
		t2 = scale_down(t * t);
		t3 = scale_down(t2 * t);
		s2 = scale_down(s * s);
		s3 = scale_down(s2 * s);
		case (mode)
		MODE_LINEAR: begin
			wt = '{s, 0, 0, t};
		end
		MODE_BEZIER: begin
			wt = '{s3, 3 * scale_down(t * s2), 3 * scale_down(t2 * s), t3};
		end
		MODE_HERMITE: begin
			wt = '{2 * t3 - 3 * t2 + ONE_L, t3 - 2 * t2 + t, 3 * t2 - 2 * t3, t3 - t2};
		end
		default: begin
			return '0;
		end
		endcase
		pts = '{w.point_a, w.point_b, w.point_c, w.point_d};
		for (int a = 0; a < NUM_LANES; a++) begin
			acc = 0;
			for (int k = 0; k < NUM_TAPS; k++)
				acc += longint'($signed(pts[k][COORD_BITS*a +: COORD_BITS])) * wt[k];
			q = scale_down(acc);
			if (q > COORD_HI)
				q = COORD_HI;
			if (q < COORD_LO)
				q = COORD_LO;
			lane[a] = coord_t'(q);
		end
		r.value_x = lane[0];
		r.value_y = lane[1];
		r.value_z = lane[2];
		return r;
	endfunction

	function automatic logic [POINT_BITS-1:0] splat(coord_t c);
		return {c, c, c};
	endfunction

	function automatic coord_t rand_coord();
		int kind;
		kind = $urandom_range(0, 3);
		if (kind == 0)
			return $urandom_range(0, 1) ? C_MAX : C_MIN;
		if (kind == 1)
			return coord_t'($urandom_range(0, 1023) - 512);
		return coord_t'($urandom);
	endfunction

	function automatic logic [T_W-1:0] rand_fraction();
		int pick;
		pick = $urandom_range(0, 19);
		if (pick == 0)
			return '0;
		if (pick == 1)
			return ONE;
		if (pick == 2)
			return T_W'($urandom_range(int'(ONE) + 1, (1 << T_W) - 1));
		return T_W'($urandom_range(0, int'(ONE)));
	endfunction

	function automatic in_word_t rand_word();
		in_word_t w;
		w.point_a = {rand_coord(), rand_coord(), rand_coord()};
		w.point_b = {rand_coord(), rand_coord(), rand_coord()};
		w.point_c = {rand_coord(), rand_coord(), rand_coord()};
		w.point_d = {rand_coord(), rand_coord(), rand_coord()};
		w.blend_fraction = rand_fraction();
		return w;
	endfunction

	task automatic send_word(input in_word_t w);
		int gap;
		gap = tx_gaps ? $urandom_range(0, 6) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_word <= w;
		do @(posedge clk); while (in_stall);
		expected_points = {expected_points, predict_point(w, cur_mode)};
		words_sent++;
		words_per_mode[cur_mode]++;
	endtask

	// mode changes only with the pipeline drained
	task automatic write_mode(input logic [1:0] m);
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_points.size() != 0);
		cfg_write <= 1'b1;
		cfg_data <= m;
		@(posedge clk);
		cfg_write <= 1'b0;
		cur_mode = m;
	endtask

	task automatic send_corner_words();
		in_word_t rw;
		rw = rand_word();
		send_word('{splat(C_MAX), splat(C_MAX), splat(C_MAX), splat(C_MAX), T_W'(0)});
		send_word('{splat(C_MIN), splat(C_MIN), splat(C_MIN), splat(C_MIN), ONE});
		send_word('{splat(C_MIN), splat(C_MAX), splat(C_MIN), splat(C_MAX), HALF});
		send_word('{splat(C_MAX), splat(C_MIN), splat(C_MAX), splat(C_MIN), {T_W{1'b1}}});
		send_word('{splat(C_MAX), splat(C_MAX), splat(C_MIN), splat(C_MAX), T_W'(1)});
		send_word('{rw.point_a, rw.point_b, splat('0), splat(coord_t'(-1)),
			ONE - T_W'(1)});
	endtask

	task automatic test_reset_mode();
		send_corner_words();
	endtask

	task automatic test_mode_extremes();
		write_mode(MODE_LINEAR);
		send_corner_words();
		write_mode(MODE_HERMITE);
		send_corner_words();
		write_mode(MODE_UNUSED);
		send_corner_words();
	endtask

	task automatic test_random_phases();
		logic [1:0] m;
		for (int p = 0; p < 12; p++) begin
			if (p < 4)
				m = 2'(p);
			else
				m = ($urandom_range(0, 7) == 0) ? MODE_UNUSED : 2'($urandom_range(0, 2));
			write_mode(m);
			tx_gaps = $urandom_range(0, 3) != 0;
			rx_gaps = $urandom_range(0, 3) != 0;
			repeat (125) send_word(rand_word());
		end
	endtask

	// sink holds off long enough for the pipeline to fill and stall the input
	task automatic test_backpressure();
		write_mode(MODE_HERMITE);
		tx_gaps = 1'b0;
		rx_gaps = 1'b1;
		hold_request = HOLD_CYCLES;
		repeat (64) send_word(rand_word());
	endtask

	task automatic check_lane(input string lane_name, input coord_t want, input coord_t got);
		if (want !== got) begin
			errors++;
			$display("%0t ns: %s expected %0d got %0d", $time, lane_name, want, got);
		end
	endtask

	initial begin : result_sink
		int wait_cycles;
		do @(posedge clk); while (!arst_n);
		forever begin
			if (hold_request > 0) begin
				out_stall <= 1'b1;
				repeat (hold_request) @(posedge clk);
				hold_request = 0;
			end else begin
				wait_cycles = rx_gaps ? $urandom_range(0, 6) : 0;
				if (wait_cycles > 0) begin
					out_stall <= 1'b1;
					repeat (wait_cycles) @(posedge clk);
				end
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_points.size() == 0) begin
				errors++;
				$display("%0t ns: unexpected word, expected none got %h", $time, out_word);
			end else begin
				next_point = expected_points.pop_front();
				check_lane("value_x", next_point.value_x, out_word.value_x);
				check_lane("value_y", next_point.value_y, out_word.value_y);
				check_lane("value_z", next_point.value_z, out_word.value_z);
				points_checked++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (in_valid && in_stall)
			in_stall_cycles++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_mode();
		test_mode_extremes();
		test_random_phases();
		test_backpressure();
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_points.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d words (linear %0d, Bezier %0d, Hermite %0d, mode 3 %0d), %0d checked",
			words_sent, words_per_mode[0], words_per_mode[1], words_per_mode[2],
			words_per_mode[3], points_checked);
		$display("Input stalled by output backpressure for %0d cycles", in_stall_cycles);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
